@@ src/urx_pkg.sv @@
// Shared types, constants and helper functions of the UART receiver with receive buffer.
// Used by the result interface and every module of the block but urx_ram; depends on nothing.
`default_nettype none

package urx_pkg;

	// Receive buffer geometry. One slot stays unused, so at most BUF_DEPTH-1 bytes are held.
	localparam int unsigned BUF_DEPTH = 64;
	localparam int unsigned PTR_W     = $clog2(BUF_DEPTH);

	localparam int unsigned DATA_W = 8;
	localparam int unsigned FILL_W = 6;
	localparam int unsigned DLY_W  = 16;
	localparam int unsigned BITS_W = 4;

	localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_DELAY   = 2'd2;

	localparam logic [DLY_W-1:0] CENTER_DELAY_RST = 16'd833;
	localparam logic [DLY_W-1:0] BIT_PERIOD_RST   = 16'd1667;
	localparam logic [DLY_W-1:0] STOP_DELAY_RST   = 16'd1667;

	// Command queue between the receive front end and the buffer back end.
	localparam int unsigned CMDQ_DEPTH = 4;
	localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CENTER,
		PH_BITS,
		PH_STOP
	} rx_phase_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [DLY_W-1:0]     data;
	} cfg_wr_t;

	// One command per tick: the pop request and, at the end of a byte, the byte to store.
	typedef struct packed {
		logic              pop;
		logic              store;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [PTR_W-1:0]  raddr;
	} ram_req_t;

	// A delay of zero behaves as a delay of one.
	function automatic logic [DLY_W-1:0] load_delay(input logic [DLY_W-1:0] v);
		return (v == '0) ? DLY_W'(1) : v;
	endfunction

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

`default_nettype wire

@@ src/urx_tick_if.sv @@
// Input channel of the UART receiver: one item per sampled line tick.
// Depends on nothing but the valid/ready handshake convention.
`default_nettype none

interface urx_tick_if;
	logic valid;
	logic ready;
	logic line_level;
	logic pop_request;

	modport source(output valid, output line_level, output pop_request, input ready);
	modport sink(input valid, input line_level, input pop_request, output ready);
endinterface

`default_nettype wire

@@ src/urx_result_if.sv @@
// Output channel of the UART receiver: one result item per input tick.
// Widths come from urx_pkg.
`default_nettype none

interface urx_result_if;
	logic                        valid;
	logic                        ready;
	logic                        pop_valid;
	logic [urx_pkg::DATA_W-1:0]  pop_data;
	logic [urx_pkg::FILL_W-1:0]  fill_level;

	modport source(output valid, output pop_valid, output pop_data, output fill_level,
		input ready);
	modport sink(input valid, input pop_valid, input pop_data, input fill_level,
		output ready);
endinterface

`default_nettype wire

@@ src/urx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module urx_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/urx_front.sv @@
// Receive front end: delay registers, bit timing state machine and byte assembly.
// Turns every accepted tick into one command for the buffer back end; uses urx_pkg.
`default_nettype none

module urx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  urx_pkg::cfg_wr_t  cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              line_level,
	input  logic              pop_request,
	output logic              push_valid,
	input  logic              push_ready,
	output urx_pkg::cmd_t     push_cmd
);

	logic [urx_pkg::DLY_W-1:0]  center_q;
	logic [urx_pkg::DLY_W-1:0]  period_q;
	logic [urx_pkg::DLY_W-1:0]  stop_q;
	urx_pkg::rx_phase_t         phase_q;
	urx_pkg::rx_phase_t         phase_d;
	logic [urx_pkg::DLY_W-1:0]  cnt_q;
	logic [urx_pkg::DLY_W-1:0]  cnt_d;
	logic [urx_pkg::DLY_W-1:0]  cnt_dec;
	logic [urx_pkg::BITS_W-1:0] bits_q;
	logic [urx_pkg::BITS_W-1:0] bits_d;
	logic [urx_pkg::BITS_W-1:0] bits_dec;
	logic [urx_pkg::DATA_W-1:0] shift_q;
	logic [urx_pkg::DATA_W-1:0] shift_d;
	logic [urx_pkg::DATA_W-1:0] shift_in;
	logic                       cnt_zero;
	logic                       last_bit;
	logic                       store;
	logic                       accept;

	assign accept     = in_valid && push_ready;
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	assign cnt_dec  = cnt_q - urx_pkg::DLY_W'(1);
	assign cnt_zero = (cnt_dec == '0);
	assign bits_dec = bits_q - urx_pkg::BITS_W'(1);
	assign last_bit = (bits_dec == '0);
	assign shift_in = {line_level, shift_q[urx_pkg::DATA_W-1:1]};

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			urx_pkg::PH_IDLE: begin
				if (!line_level) begin
					phase_d = urx_pkg::PH_CENTER;
				end
			end
			urx_pkg::PH_CENTER: begin
				if (cnt_zero) begin
					phase_d = urx_pkg::PH_BITS;
				end
			end
			urx_pkg::PH_BITS: begin
				if (cnt_zero && last_bit) begin
					phase_d = urx_pkg::PH_STOP;
				end
			end
			urx_pkg::PH_STOP: begin
				if (cnt_zero) begin
					phase_d = urx_pkg::PH_IDLE;
				end
			end
			default: phase_d = urx_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		cnt_d   = cnt_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		store   = 1'b0;
		unique case (phase_q)
			urx_pkg::PH_IDLE: begin
				if (!line_level) begin
					cnt_d = urx_pkg::load_delay(center_q);
				end
			end
			urx_pkg::PH_CENTER: begin
				cnt_d = cnt_dec;
				if (cnt_zero) begin
					cnt_d   = urx_pkg::load_delay(period_q);
					bits_d  = urx_pkg::BITS_PER_BYTE;
					shift_d = '0;
				end
			end
			urx_pkg::PH_BITS: begin
				cnt_d = cnt_dec;
				if (cnt_zero) begin
					shift_d = shift_in;
					bits_d  = bits_dec;
					if (last_bit) begin
						store = 1'b1;
						cnt_d = urx_pkg::load_delay(stop_q);
					end else begin
						cnt_d = urx_pkg::load_delay(period_q);
					end
				end
			end
			urx_pkg::PH_STOP: begin
				cnt_d = cnt_dec;
			end
			default: cnt_d = cnt_q;
		endcase
	end

	assign push_cmd = '{pop: pop_request, store: store, data: shift_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= urx_pkg::CENTER_DELAY_RST;
			period_q <= urx_pkg::BIT_PERIOD_RST;
			stop_q   <= urx_pkg::STOP_DELAY_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				urx_pkg::REG_CENTER_DELAY: center_q <= cfg.data;
				urx_pkg::REG_BIT_PERIOD:   period_q <= cfg.data;
				urx_pkg::REG_STOP_DELAY:   stop_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= urx_pkg::PH_IDLE;
			cnt_q   <= '0;
			bits_q  <= '0;
			shift_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
		end
	end

endmodule

`default_nettype wire

@@ src/urx_cmd_queue.sv @@
// Short command queue between the receive front end and the buffer back end.
// Flip-flop storage, one push and one pop per cycle; uses urx_pkg.
`default_nettype none

module urx_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  urx_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output urx_pkg::cmd_t pop_cmd
);

	urx_pkg::cmd_t                 mem_q [urx_pkg::CMDQ_DEPTH];
	logic [urx_pkg::CMDQ_PTR_W-1:0] wr_q;
	logic [urx_pkg::CMDQ_PTR_W-1:0] rd_q;
	logic [urx_pkg::CMDQ_PTR_W:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = (count_q != (urx_pkg::CMDQ_PTR_W + 1)'(urx_pkg::CMDQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + urx_pkg::CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + urx_pkg::CMDQ_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (urx_pkg::CMDQ_PTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (urx_pkg::CMDQ_PTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ src/urx_back.sv @@
// Buffer back end: ring buffer pointers, pop and store decisions and the result register.
// Drives the byte RAM through a request struct; uses urx_pkg.
`default_nettype none

module urx_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  urx_pkg::cmd_t              cmd,
	output urx_pkg::ram_req_t          ram_req,
	input  logic [urx_pkg::DATA_W-1:0] ram_rdata,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_pop_valid,
	output logic [urx_pkg::DATA_W-1:0] out_pop_data,
	output logic [urx_pkg::FILL_W-1:0] out_fill
);

	logic [urx_pkg::PTR_W-1:0] rp_q;
	logic [urx_pkg::PTR_W-1:0] wp_q;
	logic [urx_pkg::PTR_W-1:0] rp_n;
	logic [urx_pkg::PTR_W-1:0] wp_n;
	logic [urx_pkg::PTR_W:0]   fill_wide;
	logic                      valid_s2;
	logic                      pop_valid_s2;
	logic [urx_pkg::FILL_W-1:0] fill_s2;
	logic                      advance;
	logic                      pop_ok;
	logic                      store_ok;

	assign cmd_ready = !valid_s2 || out_ready;
	assign advance   = cmd_valid && cmd_ready;

	// The pop goes first; a store may then use the slot the pop has freed.
	assign pop_ok   = cmd.pop && (rp_q != wp_q);
	assign rp_n     = pop_ok ? urx_pkg::next_slot(rp_q) : rp_q;
	assign store_ok = cmd.store && (urx_pkg::next_slot(wp_q) != rp_n);
	assign wp_n     = store_ok ? urx_pkg::next_slot(wp_q) : wp_q;

	always_comb begin
		if (wp_n >= rp_n) begin
			fill_wide = {1'b0, wp_n} - {1'b0, rp_n};
		end else begin
			fill_wide = {1'b0, wp_n} + (urx_pkg::PTR_W + 1)'(urx_pkg::BUF_DEPTH) - {1'b0, rp_n};
		end
	end

	// A popped entry and the stored entry never coincide, since a pop needs rp != wp.
	assign ram_req = '{
		we:    advance && store_ok,
		waddr: wp_q,
		wdata: cmd.data,
		re:    advance && pop_ok,
		raddr: rp_q
	};

	// The RAM is read only when a result is loaded, so its data holds during a stall.
	assign out_valid     = valid_s2;
	assign out_pop_valid = pop_valid_s2;
	assign out_pop_data  = pop_valid_s2 ? ram_rdata : '0;
	assign out_fill      = fill_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q         <= '0;
			wp_q         <= '0;
			valid_s2     <= 1'b0;
			pop_valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				rp_q         <= rp_n;
				wp_q         <= wp_n;
				pop_valid_s2 <= pop_ok;
			end
			if (cmd_ready) begin
				valid_s2 <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fill_s2 <= urx_pkg::FILL_W'(fill_wide);
		end
	end

endmodule

`default_nettype wire

@@ src/uart_receiver_with_fifo.sv @@
// UART 8N1 receiver with a receive ring buffer.
// Ticks enter on the ticks channel: each item is one sample of the receive line plus a
// pop request. Results leave on the results channel, exactly one per tick, in order: the
// popped byte (zero when nothing was popped) and the buffer fill level after that tick.
// A low level while idle starts a byte; after center_delay ticks the eight data bits are
// sampled bit_period ticks apart, LSB first, and the block then waits stop_delay ticks.
// A byte that finds the buffer full (BUF_DEPTH-1 bytes held) is dropped.
// Throughput is one tick per clock cycle while results are taken. An accepted tick is
// held in the command queue; the back end then loads its result into the result register,
// together with the registered read of the byte RAM.
// Delay registers are written on cfg_we/cfg_index/cfg_data and take effect the next time
// that delay is loaded. Reset restores the delay defaults, empties the buffer and idles
// the receiver; the byte RAM itself is not cleared and no sweep is needed.
// When the results side stalls, the four-entry command queue keeps taking ticks; once it
// is full, ticks.ready drops until results are taken again.
// Depends on urx_pkg, urx_tick_if, urx_result_if, urx_ram, urx_front, urx_cmd_queue, urx_back.
`default_nettype none

module uart_receiver_with_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	urx_tick_if.sink                      ticks,
	urx_result_if.source                  results,
	input  logic                          cfg_we,
	input  logic [urx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [urx_pkg::DLY_W-1:0]     cfg_data
);

	urx_pkg::cfg_wr_t           cfg;
	logic                       q_push_valid;
	logic                       q_push_ready;
	urx_pkg::cmd_t              q_push_cmd;
	logic                       q_pop_valid;
	logic                       q_pop_ready;
	urx_pkg::cmd_t              q_pop_cmd;
	urx_pkg::ram_req_t          ram_req;
	logic [urx_pkg::DATA_W-1:0] ram_rdata;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	urx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (ticks.valid),
		.in_ready    (ticks.ready),
		.line_level  (ticks.line_level),
		.pop_request (ticks.pop_request),
		.push_valid  (q_push_valid),
		.push_ready  (q_push_ready),
		.push_cmd    (q_push_cmd)
	);

	urx_cmd_queue u_cmd_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_cmd   (q_push_cmd),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_cmd    (q_pop_cmd)
	);

	urx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (q_pop_valid),
		.cmd_ready     (q_pop_ready),
		.cmd           (q_pop_cmd),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.out_pop_valid (results.pop_valid),
		.out_pop_data  (results.pop_data),
		.out_fill      (results.fill_level)
	);

	urx_ram #(
		.WIDTH (urx_pkg::DATA_W),
		.DEPTH (urx_pkg::BUF_DEPTH)
	) u_byte_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// A stored byte must never land on the entry that is being popped.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)
		else $error("byte RAM written and read at the same entry");

	// Every RAM read belongs to a result that reports a successful pop.
	a_read_gives_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |=> results.valid && results.pop_valid)
		else $error("RAM read without a matching pop result");

	// A result can only be loaded from a command that the queue actually holds.
	a_result_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(q_pop_valid) && !$past(results.valid) |-> !results.valid)
		else $error("result appeared without a queued command");

endmodule

`default_nettype wire

@@ dv/uart_receiver_with_fifo_test.sv @@
// Self-checking testbench for the UART 8N1 receiver with its receive ring buffer.
// Drives sampled line ticks and pops, predicts every result item and compares it.
// Depends on urx_pkg, urx_tick_if, urx_result_if and uart_receiver_with_fifo.
`default_nettype none

module uart_receiver_with_fifo_test;
	import urx_pkg::*;

	typedef struct packed {
		logic lvl;
		logic pop;
	} tick_t;

	typedef struct packed {
		logic              popped;
		logic [DATA_W-1:0] data;
		logic [FILL_W-1:0] fill;
	} rx_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DLY_W-1:0]     cfg_data;

	urx_tick_if   tick_bus();
	urx_result_if result_bus();

	uart_receiver_with_fifo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.ticks    (tick_bus),
		.results  (result_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	tick_t       pending_ticks[$];
	tick_t       next_tick;
	rx_result_t  expected_results[$];
	rx_result_t  predicted;
	rx_result_t  oldest;

	int unsigned ticks_queued    = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches      = 0;
	int unsigned send_idle_pct   = 20;
	int unsigned take_idle_pct   = 20;
	int unsigned send_gap        = 0;
	int unsigned stall_left      = 0;
	int unsigned hold_left       = 0;
	bit          hold_arm        = 1'b0;
	bit          hold_done       = 1'b0;
	bit          tick_taken      = 1'b0;

	// Predicted receiver state and its copy of the delay registers.
	logic [DATA_W-1:0] rx_bytes [BUF_DEPTH];
	logic [PTR_W-1:0]  rd_ptr     = '0;
	logic [PTR_W-1:0]  wr_ptr     = '0;
	rx_phase_t         rx_phase   = PH_IDLE;
	logic [DLY_W-1:0]  rx_count   = '0;
	logic [BITS_W-1:0] rx_left    = '0;
	logic [DATA_W-1:0] rx_shift   = '0;
	logic [DLY_W-1:0]  center_reg = CENTER_DELAY_RST;
	logic [DLY_W-1:0]  period_reg = BIT_PERIOD_RST;
	logic [DLY_W-1:0]  stop_reg   = STOP_DELAY_RST;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int unsigned eff_delay(input logic [DLY_W-1:0] v);
		return (v == '0) ? 1 : int'(v);
	endfunction

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return PTR_W'((int'(p) + 1) % BUF_DEPTH);
	endfunction

	function automatic int unsigned draw_gap(input int unsigned pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(6, 16);
	endfunction

	function automatic logic roll(input int unsigned pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [DLY_W-1:0] pick_delay();
		if ($urandom_range(4) != 0)
			return DLY_W'($urandom_range(1, 4));
		return DLY_W'($urandom_range(5, 12));
	endfunction

	// One tick of the receiver: the pop is served before the receive phase advances.
	task automatic step_receiver(input logic lvl, input logic pop, output rx_result_t r);
		logic [PTR_W-1:0] slot;
		r = '0;
		if (pop && rd_ptr != wr_ptr) begin
			r.popped = 1'b1;
			r.data   = rx_bytes[rd_ptr];
			rd_ptr   = ring_next(rd_ptr);
		end
		case (rx_phase)
			PH_IDLE: begin
				if (!lvl) begin
					rx_phase = PH_CENTER;
					rx_count = DLY_W'(eff_delay(center_reg));
				end
			end
			PH_CENTER: begin
				rx_count = rx_count - 1'b1;
				if (rx_count == '0) begin
					rx_phase = PH_BITS;
					rx_count = DLY_W'(eff_delay(period_reg));
					rx_left  = BITS_PER_BYTE;
					rx_shift = '0;
				end
			end
			PH_BITS: begin
				rx_count = rx_count - 1'b1;
				if (rx_count == '0) begin
					rx_shift = {lvl, rx_shift[DATA_W-1:1]};
					rx_left  = rx_left - 1'b1;
					if (rx_left == '0) begin
						slot = ring_next(wr_ptr);
						// A full buffer drops the byte without any sign.
						if (slot != rd_ptr) begin
							rx_bytes[wr_ptr] = rx_shift;
							wr_ptr           = slot;
						end
						rx_phase = PH_STOP;
						rx_count = DLY_W'(eff_delay(stop_reg));
					end else begin
						rx_count = DLY_W'(eff_delay(period_reg));
					end
				end
			end
			default: begin
				rx_count = rx_count - 1'b1;
				if (rx_count == '0)
					rx_phase = PH_IDLE;
			end
		endcase
		r.fill = FILL_W'((int'(wr_ptr) + BUF_DEPTH - int'(rd_ptr)) % BUF_DEPTH);
	endtask

	task automatic report_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		$display("result %0d: %s expected 0x%0h, got 0x%0h", results_checked, what, want, got);
		mismatches++;
	endtask

	// Sampling at the rising edge sees the values from before the edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_taken = 1'b0;
		end else begin
			tick_taken = tick_bus.valid && tick_bus.ready;
			if (tick_taken) begin
				step_receiver(tick_bus.line_level, tick_bus.pop_request, predicted);
				expected_results.push_back(predicted);
			end
			if (result_bus.valid && result_bus.ready) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					report_mismatch("no tick pending, pop_data", 0, result_bus.pop_data);
				end else begin
					oldest = expected_results.pop_front();
					if (result_bus.pop_valid !== oldest.popped)
						report_mismatch("pop_valid", oldest.popped, result_bus.pop_valid);
					if (result_bus.pop_data !== oldest.data)
						report_mismatch("pop_data", oldest.data, result_bus.pop_data);
					if (result_bus.fill_level !== oldest.fill)
						report_mismatch("fill_level", oldest.fill, result_bus.fill_level);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			tick_bus.valid <= 1'b0;
		end else if (!tick_bus.valid || tick_taken) begin
			if (send_gap != 0) begin
				send_gap--;
				tick_bus.valid <= 1'b0;
			end else if (pending_ticks.size() != 0) begin
				next_tick = pending_ticks.pop_front();
				tick_bus.valid       <= 1'b1;
				tick_bus.line_level  <= next_tick.lvl;
				tick_bus.pop_request <= next_tick.pop;
				send_gap = draw_gap(send_idle_pct);
			end else begin
				tick_bus.valid <= 1'b0;
			end
		end
	end

	// The long hold-off of the result side runs once, when armed.
	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left = 80;
			hold_done = 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
		end
	end

	always @(negedge clk) begin
		if (!arst_n || hold_left != 0) begin
			result_bus.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= 1'b1;
			stall_left = draw_gap(take_idle_pct);
		end
	end

	task automatic queue_tick(input logic lvl, input logic pop);
		pending_ticks.push_back('{lvl: lvl, pop: pop});
		ticks_queued++;
	endtask

	task automatic wait_for_drain();
		while (results_checked < ticks_queued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DLY_W-1:0] val);
		wait_for_drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CENTER_DELAY: center_reg = val;
			REG_BIT_PERIOD:   period_reg = val;
			REG_STOP_DELAY:   stop_reg   = val;
			default: ;
		endcase
	endtask

	// A whole frame at the current delays. Noisy frames put random levels on all ticks but
	// the start and data-sample ticks; pop_on_store asks a pop on the tick the byte is stored.
	task automatic send_frame(input logic [7:0] value, input int unsigned pop_pct,
		input bit noisy, input bit pop_on_store);
		int unsigned c;
		int unsigned p;
		int unsigned s;
		logic        lvl;
		logic        pop;
		c = eff_delay(center_reg);
		p = eff_delay(period_reg);
		s = eff_delay(stop_reg);
		queue_tick(1'b0, roll(pop_pct));
		for (int t = 1; t <= c; t++)
			queue_tick(noisy ? 1'($urandom_range(1)) : 1'b0, roll(pop_pct));
		for (int k = 0; k < 8; k++) begin
			for (int t = 1; t <= p; t++) begin
				lvl = (t == p || !noisy) ? value[k] : 1'($urandom_range(1));
				pop = roll(pop_pct) || (pop_on_store && k == 7 && t == p);
				queue_tick(lvl, pop);
			end
		end
		for (int t = 1; t <= s; t++)
			queue_tick(noisy ? 1'($urandom_range(1)) : 1'b1, roll(pop_pct));
	endtask

	initial begin
		int unsigned burst_start;
		int unsigned pop_pct;
		int unsigned frames;
		int unsigned n;
		logic [7:0]  value;

		arst_n               = 1'b0;
		tick_bus.valid       = 1'b0;
		tick_bus.line_level  = 1'b1;
		tick_bus.pop_request = 1'b0;
		result_bus.ready     = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_CENTER_DELAY;
		cfg_data             = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A start at the reset center delay. The bit period and stop delay are shortened
		// while the center delay is still running, so the new values are loaded after it.
		queue_tick(1'b0, 1'b0);
		for (int t = 1; t < 820; t++)
			queue_tick(1'($urandom_range(1)), 1'b0);
		write_reg(REG_BIT_PERIOD, 16'd2);
		write_reg(REG_STOP_DELAY, 16'd1);
		for (int t = 820; t <= eff_delay(center_reg); t++)
			queue_tick(1'($urandom_range(1)), 1'b0);
		value = 8'hA5;
		for (int k = 0; k < 8; k++) begin
			queue_tick(1'($urandom_range(1)), 1'b0);
			queue_tick(value[k], 1'b0);
		end
		queue_tick(1'($urandom_range(1)), 1'b0);

		// Shortest timing, with zero delays standing for one tick.
		write_reg(REG_CENTER_DELAY, '0);
		write_reg(REG_BIT_PERIOD, '0);
		write_reg(REG_STOP_DELAY, '0);
		send_frame(8'h00, 0, 1'b0, 1'b0);
		send_frame(8'hFF, 0, 1'b0, 1'b0);
		send_frame(8'h80, 0, 1'b0, 1'b1);
		send_frame(8'h01, 100, 1'b0, 1'b0);
		repeat (3) queue_tick(1'b1, 1'b1);

		// Without pops the buffer fills up and the last byte is dropped. The result side
		// also holds off for a long stretch here while ticks keep coming.
		write_reg(REG_CENTER_DELAY, 16'd1);
		write_reg(REG_BIT_PERIOD, 16'd1);
		write_reg(REG_STOP_DELAY, 16'd1);
		send_idle_pct = 0;
		take_idle_pct = 30;
		for (int f = 0; f < 64; f++)
			send_frame(8'($urandom_range(255)), 0, 1'b0, 1'b0);
		hold_arm = 1'b1;

		burst_start = ticks_queued;
		while (ticks_queued - burst_start < 150) begin
			write_reg(REG_CENTER_DELAY, pick_delay());
			write_reg(REG_BIT_PERIOD, pick_delay());
			write_reg(REG_STOP_DELAY, pick_delay());
			send_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
			take_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
			pop_pct = $urandom_range(5, 60);
			frames = $urandom_range(2, 5);
			for (int f = 0; f < frames; f++) begin
				if ($urandom_range(5) == 0) begin
					// A glitch, then enough idle line for the receiver to settle.
					n = $urandom_range(2, 8);
					for (int j = 0; j < n; j++)
						queue_tick(1'($urandom_range(1)), roll(30));
					n = eff_delay(center_reg) + 8 * eff_delay(period_reg)
						+ eff_delay(stop_reg) + 1;
					for (int j = 0; j < n; j++)
						queue_tick(1'b1, roll(pop_pct));
				end else begin
					send_frame(8'($urandom_range(255)), pop_pct, $urandom_range(4) == 0,
						$urandom_range(3) == 0);
				end
				n = $urandom_range(0, 3);
				for (int j = 0; j < n; j++)
					queue_tick(1'b1, roll(pop_pct));
			end
		end

		write_reg(REG_CENTER_DELAY, 16'd3);
		write_reg(REG_STOP_DELAY, 16'd1);
		send_idle_pct = 20;
		take_idle_pct = 20;
		for (int f = 0; f < 3; f++)
			send_frame(8'($urandom_range(255)), 40, 1'b0, 1'b0);
		repeat (20) queue_tick(1'b1, 1'b1);

		wait_for_drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_400_000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
